FILE: hdl/cursor_ordered_list_store_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the cursor ordered list store
// Concurrent checks that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef CURSOR_ORDERED_LIST_STORE_CORE_MACROS_SVH
`define CURSOR_ORDERED_LIST_STORE_CORE_MACROS_SVH

`ifndef SYNTH

`define COLS_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define COLS_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define COLS_ASSERT(name, clk, rstn, prop, msg)

`define COLS_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: hdl/cols_pkg.sv
// ---------------------------------------------------------------------------
// cols_pkg
// Sizes, request codes and controller/datapath types of the list store.
// ---------------------------------------------------------------------------
package cols_pkg;

  localparam int CAPACITY   = 32;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = 6;   // item_count field width
  localparam int PTR_W      = $clog2(CAPACITY);
  localparam int REQ_W      = 3;
  localparam int VAL_W      = 32;  // entry_value / current_value field width

  localparam int IN_W  = ((REQ_W + VAL_W + 7) / 8) * 8;
  localparam int RES_W = VAL_W + 1 + CNT_W + 1;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_QUERY  = 3'd0,
    REQ_FIRST  = 3'd1,
    REQ_LAST   = 3'd2,
    REQ_FWD    = 3'd3,
    REQ_BACK   = 3'd4,
    REQ_INSERT = 3'd5,
    REQ_REMOVE = 3'd6
  } req_e;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_FIRST,
    DP_LAST,
    DP_FWD,
    DP_BACK,
    DP_INSERT,
    DP_REMOVE
  } dp_op_e;

  typedef enum logic {
    ST_EMPTY,
    ST_HOLD
  } ctrl_state_e;

  typedef struct packed {
    logic   load;      // execute op and load result register
    dp_op_e op;
    logic   rejected;
  } dp_cmd_t;

  typedef struct packed {
    logic has_cur;
    logic full;
  } dp_status_t;

endpackage

FILE: hdl/cols_ctrl.sv
// ---------------------------------------------------------------------------
// cols_ctrl
// Handshake control, request decode and precondition checks.
// ---------------------------------------------------------------------------
module cols_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            req_type_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  cols_pkg::dp_status_t  status_i,
  output cols_pkg::dp_cmd_t     cmd_o
);
  import cols_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    in_ready_o  = (state_q == ST_EMPTY) || out_ready_i;
    out_valid_o = (state_q == ST_HOLD);
    accept      = in_valid_i && in_ready_o;

    unique case (state_q)
      ST_EMPTY: state_d = accept ? ST_HOLD : ST_EMPTY;
      ST_HOLD:  state_d = (accept || !out_ready_i) ? ST_HOLD : ST_EMPTY;
      default:  state_d = ST_EMPTY;
    endcase

    cmd_o.load     = accept;
    cmd_o.rejected = 1'b0;
    cmd_o.op       = DP_NOP;
    unique case (req_type_i)
      REQ_FIRST: cmd_o.op = DP_FIRST;
      REQ_LAST:  cmd_o.op = DP_LAST;
      REQ_FWD: begin
        cmd_o.rejected = !status_i.has_cur;
        cmd_o.op       = status_i.has_cur ? DP_FWD : DP_NOP;
      end
      REQ_BACK: begin
        cmd_o.rejected = !status_i.has_cur;
        cmd_o.op       = status_i.has_cur ? DP_BACK : DP_NOP;
      end
      REQ_INSERT: begin
        cmd_o.rejected = status_i.full;
        cmd_o.op       = status_i.full ? DP_NOP : DP_INSERT;
      end
      REQ_REMOVE: begin
        cmd_o.rejected = !status_i.has_cur;
        cmd_o.op       = status_i.has_cur ? DP_REMOVE : DP_NOP;
      end
      default: cmd_o.op = DP_NOP;  // query and the unused code
    endcase
  end

endmodule

FILE: hdl/cols_dpath.sv
// ---------------------------------------------------------------------------
// cols_dpath
// Row of item cells with parallel shift, count, cursor and result register.
// ---------------------------------------------------------------------------
`include "cursor_ordered_list_store_core_macros.svh"

module cols_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cols_pkg::dp_cmd_t              cmd_i,
  input  logic [cols_pkg::VAL_W-1:0]     entry_value_i,
  output cols_pkg::dp_status_t           status_o,
  output logic [cols_pkg::RES_W-1:0]     result_o
);
  import cols_pkg::*;

  logic [DATA_WIDTH-1:0] cells_q [CAPACITY];
  logic [DATA_WIDTH-1:0] cells_d [CAPACITY];
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      cursor_q, cursor_d;
  logic [CNT_W-1:0]      ins_at;
  logic [DATA_WIDTH-1:0] ins_val;
  logic                  has_cur_d;
  logic [VAL_W-1:0]      cur_val_d;
  logic [RES_W-1:0]      result_q;

  assign status_o.has_cur = cursor_q < count_q;
  assign status_o.full    = count_q == CNT_W'(CAPACITY);

  // insert lands right after the current item, or at the front
  assign ins_at  = status_o.has_cur ? cursor_q + CNT_W'(1) : '0;
  assign ins_val = entry_value_i[DATA_WIDTH-1:0];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_v, next_v;
    if (g == 0) begin : g_head
      assign prev_v = cells_q[g];
    end else begin : g_body
      assign prev_v = cells_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign next_v = cells_q[g];
    end else begin : g_rest
      assign next_v = cells_q[g+1];
    end

    always_comb begin
      cells_d[g] = cells_q[g];
      if (cmd_i.load && cmd_i.op == DP_INSERT) begin
        if (CNT_W'(g) == ins_at) begin
          cells_d[g] = ins_val;
        end else if (CNT_W'(g) > ins_at) begin
          cells_d[g] = prev_v;
        end
      end else if (cmd_i.load && cmd_i.op == DP_REMOVE) begin
        if (CNT_W'(g) >= cursor_q) begin
          cells_d[g] = next_v;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      cells_q[g] <= cells_d[g];
    end
  end

  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    if (cmd_i.load) begin
      unique case (cmd_i.op)
        DP_FIRST: cursor_d = '0;
        DP_LAST:  cursor_d = (count_q != '0) ? count_q - CNT_W'(1) : '0;
        DP_FWD:   cursor_d = cursor_q + CNT_W'(1);
        DP_BACK:  cursor_d = (cursor_q == '0) ? count_q : cursor_q - CNT_W'(1);
        DP_INSERT: begin
          cursor_d = ins_at;
          count_d  = count_q + CNT_W'(1);
        end
        DP_REMOVE: count_d = count_q - CNT_W'(1);
        default: ;
      endcase
    end

    has_cur_d = cursor_d < count_d;
    cur_val_d = '0;
    if (has_cur_d) begin
      cur_val_d = VAL_W'(cells_d[cursor_d[PTR_W-1:0]]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
    end
  end

  // rejected flag in the top bit, then count, has_current, value in the low bits
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      result_q <= {cmd_i.rejected, count_d, has_cur_d, cur_val_d};
    end
  end

  assign result_o = result_q;

  `COLS_ASSERT(a_cursor_in_range, clk_i, rst_ni, cursor_q <= count_q, "cursor beyond item count")
  `COLS_ASSERT(a_count_in_range, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `COLS_ASSERT_NEXT(a_reject_keeps_state, clk_i, rst_ni, cmd_i.load && cmd_i.rejected, $stable(count_q) && $stable(cursor_q), "rejected request changed state")
  `COLS_ASSERT_NEXT(a_insert_grows, clk_i, rst_ni, cmd_i.load && cmd_i.op == DP_INSERT, count_q == $past(count_q) + CNT_W'(1), "insert did not grow count")

endmodule

FILE: hdl/cursor_ordered_list_store_core.sv
// A result reaches the master side in the cycle after the request transfer; insert
// and remove shift all cells in parallel. Throughput: one request per cycle while
// m_axis_tready is high; the result register frees itself in the cycle it is taken.
// Reset (rst_ni low, async): list empty, cursor at 0, no result pending.
// Item cells are not reset; only entries below the count are ever read.
// ---------------------------------------------------------------------------
// cursor_ordered_list_store_core
// Ordered list with cursor: move, insert, remove and query over streams.
// ---------------------------------------------------------------------------
module cursor_ordered_list_store_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // req_type[2:0], entry_value[34:3], zero pad[39:35]
  input  logic [cols_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // current_value[31:0], has_current[32], item_count[38:33], rejected[39]
  output logic [cols_pkg::OUT_W-1:0] m_axis_tdata
);
  import cols_pkg::*;

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [RES_W-1:0] result;

  cols_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tdata[REQ_W-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cols_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .entry_value_i (s_axis_tdata[REQ_W +: VAL_W]),
    .status_o      (status),
    .result_o      (result)
  );

  assign m_axis_tdata = OUT_W'(result);

endmodule
